>>> sv/swsfr_pkg.sv
`default_nettype none

package swsfr_pkg;

    // fixed field widths
    localparam int unsigned TIMEOUT_W   = 16;
    localparam int unsigned SETTLE_W    = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned BIT_INDEX_W = 6;
    localparam int unsigned FRAME_BITS  = 40;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    // most phase hand-overs one sample can pass through, plus margin
    localparam int unsigned MAX_HOPS = 4;

    // register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd32000;
    localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 6'd50;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETTLE   = 3'd1,
        PH_WAIT_LOW = 3'd2,
        PH_CAL_LOW  = 3'd3,
        PH_CAL_HIGH = 3'd4,
        PH_BIT_LOW  = 3'd5,
        PH_BIT_HIGH = 3'd6
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CHECKSUM = 2'd2
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   humidity_int;
        logic [BYTE_W-1:0]   humidity_frac;
        logic [BYTE_W-1:0]   temperature_int;
        logic [BYTE_W-1:0]   temperature_frac;
        logic [BYTE_W-1:0]   check_byte;
    } result_t;

endpackage

`default_nettype wire

>>> sv/swsfr_sample_if.sv
`default_nettype none

interface swsfr_sample_if;
    logic valid;
    logic ready;
    logic start_req;
    logic pin_level;

    modport source (output valid, output start_req, output pin_level, input ready);
    modport sink (input valid, input start_req, input pin_level, output ready);
endinterface

`default_nettype wire

>>> sv/swsfr_result_if.sv
`default_nettype none

interface swsfr_result_if
    import swsfr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   humidity_int;
    logic [BYTE_W-1:0]   humidity_frac;
    logic [BYTE_W-1:0]   temperature_int;
    logic [BYTE_W-1:0]   temperature_frac;
    logic [BYTE_W-1:0]   check_byte;

    modport source (
        output valid, output status, output humidity_int, output humidity_frac,
        output temperature_int, output temperature_frac, output check_byte,
        input ready
    );
    modport sink (
        input valid, input status, input humidity_int, input humidity_frac,
        input temperature_int, input temperature_frac, input check_byte,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/swsfr_cfg_if.sv
`default_nettype none

interface swsfr_cfg_if
    import swsfr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/swsfr_step.sv
`default_nettype none

module swsfr_step
    import swsfr_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  wire phase_t                  phase,
    input  wire [COUNTER_BITS-1:0]       counter,
    input  wire [COUNTER_BITS:0]         cal_sum,
    input  wire [BIT_INDEX_W-1:0]        bit_index,
    input  wire [FRAME_BITS-1:0]         frame,
    input  wire                          start_req,
    input  wire                          pin_level,
    input  wire [TIMEOUT_W-1:0]          timeout_limit,
    input  wire [SETTLE_W-1:0]           settle_limit,
    output phase_t                       phase_next,
    output logic [COUNTER_BITS-1:0]      counter_next,
    output logic [COUNTER_BITS:0]        cal_sum_next,
    output logic [BIT_INDEX_W-1:0]       bit_index_next,
    output logic [FRAME_BITS-1:0]        frame_next,
    output logic                         emit,
    output result_t                      result
);

    // width wide enough for both the counter and the timeout limit
    localparam int unsigned CMP_W = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;

    phase_t                  ph;
    logic [COUNTER_BITS-1:0] cnt;
    logic [COUNTER_BITS:0]   sum;
    logic [BIT_INDEX_W-1:0]  idx;
    logic [FRAME_BITS-1:0]   shf;
    logic                    done;
    logic                    tick;
    logic                    bit_val;
    logic [BYTE_W-1:0]       byte_sum;

    // one sample walks through the phase chain; a phase that ends hands the
    // same sample to the next phase
    always_comb
    begin
        ph       = phase;
        cnt      = counter;
        sum      = cal_sum;
        idx      = bit_index;
        shf      = frame;
        done     = 1'b0;
        tick     = 1'b0;
        bit_val  = 1'b0;
        byte_sum = '0;
        emit     = 1'b0;
        result   = '0;

        // start request restarts the read from settle
        if (start_req)
        begin
            ph  = PH_SETTLE;
            cnt = '0;
            sum = '0;
            idx = '0;
            shf = '0;
        end

        for (int k = 0; k < MAX_HOPS; k++)
        begin
            tick = 1'b0;
            if (!done)
            begin
                case (ph)
                    PH_IDLE:
                    begin
                        done = 1'b1;
                    end
                    PH_SETTLE:
                    begin
                        if (!pin_level && (cnt < COUNTER_BITS'(settle_limit)))
                        begin
                            cnt  = cnt + 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            ph  = PH_WAIT_LOW;
                            cnt = '0;
                        end
                    end
                    PH_WAIT_LOW:
                    begin
                        if (pin_level)
                        begin
                            tick = 1'b1;
                        end
                        else
                        begin
                            ph  = PH_CAL_LOW;
                            cnt = '0;
                        end
                    end
                    PH_CAL_LOW:
                    begin
                        if (!pin_level)
                        begin
                            tick = 1'b1;
                        end
                        else
                        begin
                            sum = (COUNTER_BITS + 1)'(cnt);
                            ph  = PH_CAL_HIGH;
                            cnt = '0;
                        end
                    end
                    PH_CAL_HIGH:
                    begin
                        if (pin_level)
                        begin
                            tick = 1'b1;
                        end
                        else
                        begin
                            sum = sum + (COUNTER_BITS + 1)'(cnt);
                            ph  = PH_BIT_LOW;
                            cnt = '0;
                        end
                    end
                    PH_BIT_LOW:
                    begin
                        if (!pin_level)
                        begin
                            tick = 1'b1;
                        end
                        else
                        begin
                            ph  = PH_BIT_HIGH;
                            cnt = '0;
                        end
                    end
                    PH_BIT_HIGH:
                    begin
                        if (pin_level)
                        begin
                            tick = 1'b1;
                        end
                        else
                        begin
                            // threshold is a quarter of the calibration sum
                            bit_val = ((COUNTER_BITS + 1)'(cnt) >= (sum >> 2));
                            shf     = {shf[FRAME_BITS-2:0], bit_val};
                            idx     = idx + 1'b1;
                            if (idx >= BIT_INDEX_W'(FRAME_BITS))
                            begin
                                byte_sum = shf[39:32] + shf[31:24] + shf[23:16] + shf[15:8];
                                emit                    = 1'b1;
                                result.status           = (byte_sum == shf[7:0]) ?
                                                          ST_OK : ST_CHECKSUM;
                                result.humidity_int     = shf[39:32];
                                result.humidity_frac    = shf[31:24];
                                result.temperature_int  = shf[23:16];
                                result.temperature_frac = shf[15:8];
                                result.check_byte       = shf[7:0];
                                ph                      = PH_IDLE;
                                done                    = 1'b1;
                            end
                            else
                            begin
                                ph  = PH_BIT_LOW;
                                cnt = '0;
                            end
                        end
                    end
                    default:
                    begin
                        ph   = PH_IDLE;
                        done = 1'b1;
                    end
                endcase

                // phase keeps going: count the sample and check for timeout
                if (tick)
                begin
                    cnt  = cnt + 1'b1;
                    done = 1'b1;
                    if (CMP_W'(cnt) >= CMP_W'(timeout_limit))
                    begin
                        emit          = 1'b1;
                        result        = '0;
                        result.status = ST_TIMEOUT;
                        ph            = PH_IDLE;
                    end
                end
            end
        end

        phase_next     = ph;
        counter_next   = cnt;
        cal_sum_next   = sum;
        bit_index_next = idx;
        frame_next     = shf;
    end

endmodule

`default_nettype wire

>>> sv/single_wire_sensor_frame_receiver_top.sv
// Single-wire sensor frame receiver.
// sample_ch carries one sample of the sensor data line per transfer
// (pin_level) and a start_req flag that begins a new read with that sample.
// Pulse widths are counted in samples, so the source is expected to present
// one sample per clock; the block takes one transfer a cycle unless stalled.
// result_ch carries one result per finished read: status (success, timeout
// or checksum mismatch) and the five received bytes; a timeout reports all
// bytes as zero. A new start during a read drops it without a result.
// cfg_ch writes timeout_limit (index 0) and settle_limit (index 1); it is
// always ready and should only be written while no read is running.
// A sample accepted into the input register is evaluated combinationally
// from that register, and a result it produces is captured in the output
// register. The block can take a new sample while the previous one is
// being evaluated, so one sample per cycle passes when nothing stalls.
// When result_ch stalls, the held result waits in the output register and
// sample transfers continue as long as the evaluated sample produces no
// further result; otherwise sample_ch deasserts ready until the result moves.
// Reset clears the read state to idle, drops queued samples and results and
// restores both configuration registers to their default values.
`default_nettype none

module single_wire_sensor_frame_receiver_top
    import swsfr_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    swsfr_sample_if.sink     sample_ch,
    swsfr_result_if.source   result_ch,
    swsfr_cfg_if.sink        cfg_ch
);

    logic [TIMEOUT_W-1:0]    timeout_limit_reg;
    logic [SETTLE_W-1:0]     settle_limit_reg;

    logic                    in_valid_reg;
    logic                    start_req_reg;
    logic                    pin_level_reg;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [COUNTER_BITS-1:0] counter_reg;
    logic [COUNTER_BITS-1:0] counter_next;
    logic [COUNTER_BITS:0]   cal_sum_reg;
    logic [COUNTER_BITS:0]   cal_sum_next;
    logic [BIT_INDEX_W-1:0]  bit_index_reg;
    logic [BIT_INDEX_W-1:0]  bit_index_next;
    logic [FRAME_BITS-1:0]   frame_reg;
    logic [FRAME_BITS-1:0]   frame_next;

    logic                    out_valid_reg;
    result_t                 result_reg;
    result_t                 step_result;
    logic                    step_emit;
    logic                    fire;
    logic                    in_ready;

    // configuration writes
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg <= TIMEOUT_RESET;
            settle_limit_reg  <= SETTLE_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_ch.data[TIMEOUT_W-1:0];
                CFG_SETTLE_LIMIT:  settle_limit_reg  <= cfg_ch.data[SETTLE_W-1:0];
                default:           ;
            endcase
        end
    end

    // phase evaluation of the registered sample
    swsfr_step #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_step (
        .phase          (phase_reg),
        .counter        (counter_reg),
        .cal_sum        (cal_sum_reg),
        .bit_index      (bit_index_reg),
        .frame          (frame_reg),
        .start_req      (start_req_reg),
        .pin_level      (pin_level_reg),
        .timeout_limit  (timeout_limit_reg),
        .settle_limit   (settle_limit_reg),
        .phase_next     (phase_next),
        .counter_next   (counter_next),
        .cal_sum_next   (cal_sum_next),
        .bit_index_next (bit_index_next),
        .frame_next     (frame_next),
        .emit           (step_emit),
        .result         (step_result)
    );

    // sample is evaluated unless its result would overwrite a held one
    assign fire     = in_valid_reg && (!step_emit || !out_valid_reg || result_ch.ready);
    assign in_ready = !in_valid_reg || fire;
    assign sample_ch.ready = in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= sample_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && sample_ch.valid)
        begin
            start_req_reg <= sample_ch.start_req;
            pin_level_reg <= sample_ch.pin_level;
        end
    end

    // read state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            counter_reg   <= '0;
            cal_sum_reg   <= '0;
            bit_index_reg <= '0;
            frame_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            counter_reg   <= counter_next;
            cal_sum_reg   <= cal_sum_next;
            bit_index_reg <= bit_index_next;
            frame_reg     <= frame_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && step_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && step_emit)
        begin
            result_reg <= step_result;
        end
    end

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.status           = result_reg.status;
    assign result_ch.humidity_int     = result_reg.humidity_int;
    assign result_ch.humidity_frac    = result_reg.humidity_frac;
    assign result_ch.temperature_int  = result_reg.temperature_int;
    assign result_ch.temperature_frac = result_reg.temperature_frac;
    assign result_ch.check_byte       = result_reg.check_byte;

endmodule

`default_nettype wire

>>> sv/swsfr_checker.sv
`default_nettype none

module swsfr_checker
    import swsfr_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                cfg_ready,
    input wire                out_valid,
    input wire                out_ready,
    input wire [STATUS_W-1:0] status,
    input wire [BYTE_W-1:0]   humidity_int,
    input wire [BYTE_W-1:0]   humidity_frac,
    input wire [BYTE_W-1:0]   temperature_int,
    input wire [BYTE_W-1:0]   temperature_frac,
    input wire [BYTE_W-1:0]   check_byte
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // stalled result keeps its status and check byte
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(check_byte))
        else $error("result changed while stalled");

    // timeout carries no frame bytes
    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_TIMEOUT) |->
            (humidity_int == '0) && (humidity_frac == '0) && (temperature_int == '0)
            && (temperature_frac == '0) && (check_byte == '0))
        else $error("timeout result with frame bytes");

    // success only with a matching checksum, mismatch only without
    a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_TIMEOUT) |->
            ((check_byte == BYTE_W'(humidity_int + humidity_frac + temperature_int
                                    + temperature_frac)) == (status == ST_OK)))
        else $error("status does not match checksum");

    // configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind single_wire_sensor_frame_receiver_top swsfr_checker u_swsfr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_ready        (cfg_ch.ready),
    .out_valid        (result_ch.valid),
    .out_ready        (result_ch.ready),
    .status           (result_ch.status),
    .humidity_int     (result_ch.humidity_int),
    .humidity_frac    (result_ch.humidity_frac),
    .temperature_int  (result_ch.temperature_int),
    .temperature_frac (result_ch.temperature_frac),
    .check_byte       (result_ch.check_byte)
);

`default_nettype wire

>>> test/tb_single_wire_sensor_frame_receiver_top.sv
`timescale 1ns / 100ps

module tb_single_wire_sensor_frame_receiver_top
    import swsfr_pkg::*;
;

    localparam int unsigned CNT_W = 16;
    localparam int IDLE_LIMIT     = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_GOAL      = 1550;
    localparam int TAIL_ITEMS     = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_MAX     = 10;

    typedef enum logic [1:0] {
        ROW_QUIET,
        ROW_TIMEOUT,
        ROW_TRACKED
    } row_kind_t;

    typedef struct packed {
        logic      start;
        logic      pin;
        row_kind_t kind;
    } sample_row_t;

    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_CUT,
        FLAW_GLITCH
    } flaw_t;

    logic clk;
    logic rst_n;

    swsfr_sample_if sample_ch();
    swsfr_result_if result_ch();
    swsfr_cfg_if    cfg_ch();

    single_wire_sensor_frame_receiver_top #(
        .COUNTER_BITS(CNT_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // receiver state tracked alongside the block
    logic [TIMEOUT_W-1:0]   timeout_lim;
    logic [SETTLE_W-1:0]    settle_lim;
    phase_t                 rx_phase;
    logic [CNT_W-1:0]       pulse_cnt;
    logic [CNT_W:0]         cal_sum;
    logic [BIT_INDEX_W-1:0] bits_seen;
    logic [FRAME_BITS-1:0]  frame_bits;

    result_t pending_results[$];
    int      item_count;
    int      result_count;
    int      mismatch_count;
    int      idle_cycles;
    bit      gaps_on;
    bit      hold_req;
    bit      holding;

    // directed samples: timeout_limit 2, settle_limit 2
    sample_row_t directed_rows[26] = '{
        '{1'b0, 1'b1, ROW_QUIET},
        '{1'b1, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TIMEOUT},
        '{1'b0, 1'b0, ROW_QUIET},
        '{1'b1, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TIMEOUT},
        '{1'b1, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TRACKED},
        '{1'b1, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TIMEOUT},
        '{1'b1, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TIMEOUT},
        '{1'b1, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b0, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TRACKED},
        '{1'b0, 1'b1, ROW_TIMEOUT}
    };

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // count one more sample in a waiting phase, flag the timeout
    function automatic bit count_expired();
        pulse_cnt = pulse_cnt + 1'b1;
        return pulse_cnt >= timeout_lim;
    endfunction

    // one line sample through the receiver; returns 1 when a result is due
    function automatic bit decode_sample(input logic start, input logic pin,
                                         output result_t res);
        bit                settled;
        bit                expired;
        bit                framed;
        logic              bit_val;
        logic [BYTE_W-1:0] sum;
        res     = '0;
        settled = 1'b0;
        expired = 1'b0;
        framed  = 1'b0;
        if (start)
        begin
            rx_phase   = PH_SETTLE;
            pulse_cnt  = '0;
            cal_sum    = '0;
            bits_seen  = '0;
            frame_bits = '0;
        end
        // the sample that ends a phase is examined again by the next one
        for (int hop = 0; hop < 2 * MAX_HOPS && !settled; hop++)
        begin
            case (rx_phase)
                PH_SETTLE:
                begin
                    if (!pin && pulse_cnt < settle_lim)
                    begin
                        pulse_cnt = pulse_cnt + 1'b1;
                        settled   = 1'b1;
                    end
                    else
                    begin
                        rx_phase  = PH_WAIT_LOW;
                        pulse_cnt = '0;
                    end
                end
                PH_WAIT_LOW:
                begin
                    if (pin)
                    begin
                        expired = count_expired();
                        settled = 1'b1;
                    end
                    else
                    begin
                        rx_phase  = PH_CAL_LOW;
                        pulse_cnt = '0;
                    end
                end
                PH_CAL_LOW:
                begin
                    if (!pin)
                    begin
                        expired = count_expired();
                        settled = 1'b1;
                    end
                    else
                    begin
                        cal_sum   = {1'b0, pulse_cnt};
                        rx_phase  = PH_CAL_HIGH;
                        pulse_cnt = '0;
                    end
                end
                PH_CAL_HIGH:
                begin
                    if (pin)
                    begin
                        expired = count_expired();
                        settled = 1'b1;
                    end
                    else
                    begin
                        cal_sum   = cal_sum + {1'b0, pulse_cnt};
                        rx_phase  = PH_BIT_LOW;
                        pulse_cnt = '0;
                    end
                end
                PH_BIT_LOW:
                begin
                    if (!pin)
                    begin
                        expired = count_expired();
                        settled = 1'b1;
                    end
                    else
                    begin
                        rx_phase  = PH_BIT_HIGH;
                        pulse_cnt = '0;
                    end
                end
                PH_BIT_HIGH:
                begin
                    if (pin)
                    begin
                        expired = count_expired();
                        settled = 1'b1;
                    end
                    else
                    begin
                        // high pulse of at least a quarter of the calibration is a one
                        bit_val    = ({1'b0, pulse_cnt} >= (cal_sum >> 2));
                        frame_bits = {frame_bits[FRAME_BITS-2:0], bit_val};
                        bits_seen  = bits_seen + 1'b1;
                        if (bits_seen >= FRAME_BITS)
                        begin
                            res.humidity_int     = frame_bits[39:32];
                            res.humidity_frac    = frame_bits[31:24];
                            res.temperature_int  = frame_bits[23:16];
                            res.temperature_frac = frame_bits[15:8];
                            res.check_byte       = frame_bits[7:0];
                            sum = res.humidity_int + res.humidity_frac
                                + res.temperature_int + res.temperature_frac;
                            res.status = (res.check_byte == sum) ? ST_OK : ST_CHECKSUM;
                            rx_phase   = PH_IDLE;
                            framed     = 1'b1;
                            settled    = 1'b1;
                        end
                        else
                        begin
                            rx_phase  = PH_BIT_LOW;
                            pulse_cnt = '0;
                        end
                    end
                end
                default:
                begin
                    rx_phase = PH_IDLE;
                    settled  = 1'b1;
                end
            endcase
        end
        if (expired)
        begin
            res        = '0;
            res.status = ST_TIMEOUT;
            rx_phase   = PH_IDLE;
        end
        return expired || framed;
    endfunction

    // one sample transfer, with random gaps before it
    task automatic send_sample(input logic start, input logic pin, input row_kind_t kind);
        result_t res;
        bit      has_res;
        while (gaps_on && $urandom_range(99) < 22)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.start_req <= start;
        sample_ch.pin_level <= pin;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        item_count++;
        has_res = decode_sample(start, pin, res);
        case (kind)
            ROW_TIMEOUT:
            begin
                res        = '0;
                res.status = ST_TIMEOUT;
                pending_results.push_back(res);
                result_count++;
            end
            ROW_TRACKED:
            begin
                if (has_res)
                begin
                    pending_results.push_back(res);
                    result_count++;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // stop sending, let every result arrive, then give the pipeline time to empty
    task automatic wait_for_idle();
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both limit registers, written back to back
    task automatic program_limits(input logic [TIMEOUT_W-1:0] tmo,
                                  input logic [SETTLE_W-1:0] settle);
        logic [CFG_DATA_W-1:0] settle_word;
        settle_word = {10'($urandom_range(1023)), settle};
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_TIMEOUT_LIMIT;
        cfg_ch.data  <= tmo;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        timeout_lim = tmo;
        cfg_ch.index <= CFG_SETTLE_LIMIT;
        cfg_ch.data  <= settle_word;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        settle_lim = settle_word[SETTLE_W-1:0];
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void add_run(ref logic levels[$], input logic lvl, input int n);
        repeat (n) levels.push_back(lvl);
    endfunction

    // a sensor frame with random bytes, optionally cut short or glitched
    task automatic send_frame(input flaw_t flaw);
        logic [BYTE_W-1:0] bytes_out[5];
        logic [BYTE_W-1:0] sum;
        logic              levels[$];
        int                s_lows;
        int                cal_lo;
        int                cal_hi;
        int                thr;
        int                pos;
        sum = '0;
        for (int j = 0; j < 4; j++)
        begin
            case ($urandom_range(3))
                0:       bytes_out[j] = 8'h00;
                1:       bytes_out[j] = 8'hFF;
                default: bytes_out[j] = 8'($urandom_range(255));
            endcase
            sum = sum + bytes_out[j];
        end
        bytes_out[4] = ($urandom_range(9) < 7) ? sum : 8'($urandom_range(255));

        // settle lows never exceed the limit, so the response high ends settle
        s_lows = ($urandom_range(2) == 0) ? int'(settle_lim)
                                          : $urandom_range(int'(settle_lim), 0);
        cal_lo = $urandom_range(10, 4);
        cal_hi = $urandom_range(10, 4);
        thr    = (cal_lo + cal_hi) >> 2;
        add_run(levels, 1'b0, s_lows);
        add_run(levels, 1'b1, $urandom_range(4, 1));
        add_run(levels, 1'b0, cal_lo);
        add_run(levels, 1'b1, cal_hi);
        for (int j = 0; j < 5; j++)
        begin
            for (int b = BYTE_W - 1; b >= 0; b--)
            begin
                add_run(levels, 1'b0, $urandom_range(2, 1));
                if (bytes_out[j][b])
                    add_run(levels, 1'b1, $urandom_range(thr + 3, thr));
                else
                    add_run(levels, 1'b1, $urandom_range(thr - 1, 1));
            end
        end
        add_run(levels, 1'b0, 1);

        case (flaw)
            FLAW_CUT:
            begin
                pos    = $urandom_range(levels.size() - 1, 1);
                levels = levels[0:pos-1];
            end
            FLAW_GLITCH:
            begin
                pos         = $urandom_range(levels.size() - 1, 1);
                levels[pos] = !levels[pos];
            end
            default:
            begin
            end
        endcase

        foreach (levels[i])
            send_sample(i == 0, levels[i], ROW_TRACKED);
    endtask

    // random line noise with occasional start requests
    task automatic send_noise();
        repeat ($urandom_range(30, 1))
            send_sample($urandom_range(7) == 0, 1'($urandom_range(1)), ROW_TRACKED);
    endtask

    task automatic log_bad_result(input string why, input result_t exp, input result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s: expected status %0d bytes %h, got status %0d bytes %h",
                     why, exp.status, exp[39:0], got.status, got[39:0]);
    endtask

    // result checker
    initial
    begin
        result_t got;
        result_t exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.status           = status_t'(result_ch.status);
                got.humidity_int     = result_ch.humidity_int;
                got.humidity_frac    = result_ch.humidity_frac;
                got.temperature_int  = result_ch.temperature_int;
                got.temperature_frac = result_ch.temperature_frac;
                got.check_byte       = result_ch.check_byte;
                if (pending_results.size() == 0)
                    log_bad_result("result with nothing pending", '0, got);
                else
                begin
                    exp = pending_results.pop_front();
                    if (got.status !== exp.status
                        || got.humidity_int !== exp.humidity_int
                        || got.humidity_frac !== exp.humidity_frac
                        || got.temperature_int !== exp.temperature_int
                        || got.temperature_frac !== exp.temperature_frac
                        || got.check_byte !== exp.check_byte)
                        log_bad_result("result mismatch", exp, got);
                end
            end
        end
    end

    // result ready: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
                if (hold_left == 0)
                    holding = 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                holding   = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !(gaps_on && $urandom_range(99) < 22);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_single_wire_sensor_frame_receiver_top failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int pick;
        rst_n               <= 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.start_req <= 1'b0;
        sample_ch.pin_level <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_TIMEOUT_LIMIT;
        cfg_ch.data         <= '0;
        timeout_lim    = TIMEOUT_RESET;
        settle_lim     = SETTLE_RESET;
        rx_phase       = PH_IDLE;
        pulse_cnt      = '0;
        cal_sum        = '0;
        bits_seen      = '0;
        frame_bits     = '0;
        item_count     = 0;
        result_count   = 0;
        mismatch_count = 0;
        gaps_on        = 1'b1;
        hold_req       = 1'b0;
        holding        = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one timeout per waiting phase, idle samples and a restart mid-read
        program_limits(16'd2, 6'd2);
        foreach (directed_rows[i])
            send_sample(directed_rows[i].start, directed_rows[i].pin, directed_rows[i].kind);

        // random frames under a series of limit settings
        for (int k = 0; k < 5; k++)
        begin
            wait_for_idle();
            case (k)
                0:       program_limits(16'd1, 6'd0);
                1:       program_limits(16'hFFFF, 6'd63);
                2:       program_limits(16'd9, 6'd1);
                3:       program_limits(TIMEOUT_RESET, SETTLE_RESET);
                default: program_limits($urandom_range(1) ? 16'($urandom_range(40, 6))
                                                          : 16'($urandom_range(65535, 41)),
                                        6'($urandom_range(63)));
            endcase
            gaps_on = (k != 1);

            // every start times out at once here, so a stalled output backs up the input
            if (k == 0)
            begin
                hold_req = 1'b1;
                wait (holding);
                repeat (24) send_sample(1'b1, 1'($urandom_range(1)), ROW_TRACKED);
            end

            // the random setting takes mixed traffic until the item budget is nearly spent
            if (k == 4)
            begin
                while (item_count + TAIL_ITEMS < ITEM_GOAL)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        send_frame(FLAW_NONE);
                    else if (pick < 80)
                        send_frame(FLAW_CUT);
                    else if (pick < 88)
                        send_frame(FLAW_GLITCH);
                    else
                        send_noise();
                end
            end
            // a clean frame always ends the read, so the limits can change next
            send_frame(FLAW_NONE);
        end

        wait_for_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_single_wire_sensor_frame_receiver_top passed");
        else
            $display("tb_single_wire_sensor_frame_receiver_top failed");
        $finish;
    end

endmodule

>>> files.f
sv/swsfr_pkg.sv
sv/swsfr_sample_if.sv
sv/swsfr_result_if.sv
sv/swsfr_cfg_if.sv
sv/swsfr_step.sv
sv/single_wire_sensor_frame_receiver_top.sv
sv/swsfr_checker.sv
test/tb_single_wire_sensor_frame_receiver_top.sv
